// ===== hw/rtl/rtcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcsp_pkg
// Shared types, codes and default sizes for the two-class slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcsp_pkg;

    // default pool geometry
    localparam int SMALL_SLOTS_DEF = 8;
    localparam int LARGE_SLOTS_DEF = 4;
    localparam int REF_BITS_DEF    = 8;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 16;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST = 16'd64;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RST    = 16'd512;

    typedef enum logic {
        REG_SMALL_LIMIT = 1'b0,
        REG_MAX_SIZE    = 1'b1
    } reg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RETAIN  = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_NULL      = 3'd3,
        ST_COUNT     = 3'd4
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic execute;  // run the latched item, update slots, load result
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/refcounted_two_class_slot_pool.sv =====
// ----------------------------------------------------------------------------
// refcounted_two_class_slot_pool
// Reference-counted pool of small and large slots with acquire/retain/release.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   in       | to block  | in_valid / in_ready  | cmd, request_size, slot_index
//   out      | from block| out_valid / out_ready| status, granted_slot, was_last
//   config   | to block  | APB psel/penable     | paddr, pwdata, prdata
//
// Each item is latched, then the slot table is searched and updated and the
// result register is loaded. A held result may leave in the same cycle the
// next item enters. rst_n frees every slot and zeroes counts; no clearing
// pass. A stalled output holds the result and blocks new items.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_two_class_slot_pool #(
    parameter int SMALL_SLOTS = rtcsp_pkg::SMALL_SLOTS_DEF,
    parameter int LARGE_SLOTS = rtcsp_pkg::LARGE_SLOTS_DEF,
    parameter int REF_BITS    = rtcsp_pkg::REF_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rtcsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [rtcsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [rtcsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [rtcsp_pkg::CMD_W-1:0]       cmd,
    input  wire logic [rtcsp_pkg::SIZE_W-1:0]      request_size,
    input  wire logic [rtcsp_pkg::IDX_W-1:0]       slot_index,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [rtcsp_pkg::STATUS_W-1:0]    status,
    output logic      [rtcsp_pkg::IDX_W-1:0]       granted_slot,
    output logic                                   was_last
);

    logic [rtcsp_pkg::SIZE_W-1:0] small_limit;
    logic [rtcsp_pkg::SIZE_W-1:0] max_size;
    rtcsp_pkg::ctrl_cmd_t         ctrl_cmd;

    rtcsp_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .small_limit (small_limit),
        .max_size    (max_size)
    );

    rtcsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (ctrl_cmd)
    );

    rtcsp_datapath #(
        .SMALL_SLOTS (SMALL_SLOTS),
        .LARGE_SLOTS (LARGE_SLOTS),
        .REF_BITS    (REF_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .cmd_in       (cmd),
        .size_in      (request_size),
        .idx_in       (slot_index),
        .small_limit  (small_limit),
        .max_size     (max_size),
        .status       (status),
        .granted_slot (granted_slot),
        .was_last     (was_last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rtcsp_regs.sv =====
// ----------------------------------------------------------------------------
// rtcsp_regs
// APB configuration registers: small class size limit and maximum request.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcsp_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rtcsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [rtcsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [rtcsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output logic      [rtcsp_pkg::SIZE_W-1:0]      small_limit,
    output logic      [rtcsp_pkg::SIZE_W-1:0]      max_size
);

    logic [rtcsp_pkg::SIZE_W-1:0] small_limit_reg;
    logic [rtcsp_pkg::SIZE_W-1:0] max_size_reg;
    logic                         wr_en;
    rtcsp_pkg::reg_idx_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = rtcsp_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_limit_reg <= rtcsp_pkg::SMALL_LIMIT_RST;
            max_size_reg    <= rtcsp_pkg::MAX_SIZE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                rtcsp_pkg::REG_SMALL_LIMIT: small_limit_reg <= pwdata[rtcsp_pkg::SIZE_W-1:0];
                rtcsp_pkg::REG_MAX_SIZE:    max_size_reg    <= pwdata[rtcsp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            rtcsp_pkg::REG_SMALL_LIMIT:
                prdata = {{(rtcsp_pkg::APB_DATA_W-rtcsp_pkg::SIZE_W){1'b0}}, small_limit_reg};
            rtcsp_pkg::REG_MAX_SIZE:
                prdata = {{(rtcsp_pkg::APB_DATA_W-rtcsp_pkg::SIZE_W){1'b0}}, max_size_reg};
            default:
                prdata = '0;
        endcase
    end

    assign small_limit = small_limit_reg;
    assign max_size    = max_size_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rtcsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtcsp_ctrl
// Item sequencer: accept, execute, hold result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcsp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rtcsp_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // a new item may enter while the held result leaves in the same cycle
    assign in_ready    = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC);
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_valid_reg && out_ready)
                        out_valid_reg <= 1'b0;
                    if (cmd.capture)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rtcsp_datapath.sv =====
// ----------------------------------------------------------------------------
// rtcsp_datapath
// Slot table, first-free search, count update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcsp_datapath #(
    parameter int SMALL_SLOTS = rtcsp_pkg::SMALL_SLOTS_DEF,
    parameter int LARGE_SLOTS = rtcsp_pkg::LARGE_SLOTS_DEF,
    parameter int REF_BITS    = rtcsp_pkg::REF_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rtcsp_pkg::ctrl_cmd_t            cmd,
    input  wire logic [rtcsp_pkg::CMD_W-1:0]     cmd_in,
    input  wire logic [rtcsp_pkg::SIZE_W-1:0]    size_in,
    input  wire logic [rtcsp_pkg::IDX_W-1:0]     idx_in,
    input  wire logic [rtcsp_pkg::SIZE_W-1:0]    small_limit,
    input  wire logic [rtcsp_pkg::SIZE_W-1:0]    max_size,
    output logic      [rtcsp_pkg::STATUS_W-1:0]  status,
    output logic      [rtcsp_pkg::IDX_W-1:0]     granted_slot,
    output logic                                 was_last
);

    localparam int TOTAL  = SMALL_SLOTS + LARGE_SLOTS;
    localparam int SLOT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    // latched item
    logic [rtcsp_pkg::CMD_W-1:0]  cmd_reg;
    logic [rtcsp_pkg::SIZE_W-1:0] size_reg;
    logic [rtcsp_pkg::IDX_W-1:0]  idx_reg;

    // slot table
    logic [TOTAL-1:0]             busy_reg;
    logic [REF_BITS-1:0]          refs_reg [TOTAL];
    logic [rtcsp_pkg::SIZE_W-1:0] len_reg  [TOTAL];

    // result
    logic [rtcsp_pkg::STATUS_W-1:0] status_reg;
    logic [rtcsp_pkg::IDX_W-1:0]    grant_reg;
    logic                           last_reg;

    logic                           small_found;
    logic [SLOT_W-1:0]              small_sel;
    logic                           large_found;
    logic [SLOT_W-1:0]              large_sel;
    logic                           idx_ok;
    logic [SLOT_W-1:0]              idx_sel;
    logic [REF_BITS-1:0]            refs_at;
    logic [REF_BITS-1:0]            refs_dec;

    rtcsp_pkg::status_t             status_next;
    logic [rtcsp_pkg::IDX_W-1:0]    grant_next;
    logic                           last_next;
    logic                           wr_en;
    logic [SLOT_W-1:0]              wr_slot;
    logic                           wr_busy;
    logic [REF_BITS-1:0]            wr_refs;
    logic [rtcsp_pkg::SIZE_W-1:0]   wr_len;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= cmd_in;
            size_reg <= size_in;
            idx_reg  <= idx_in;
        end
    end

    // priority encoders, lowest free slot of each class
    always_comb
    begin
        small_found = 1'b0;
        small_sel   = '0;
        for (int i = SMALL_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                small_found = 1'b1;
                small_sel   = SLOT_W'(i);
            end
        end
        large_found = 1'b0;
        large_sel   = '0;
        for (int j = TOTAL - 1; j >= SMALL_SLOTS; j--)
        begin
            if (!busy_reg[j])
            begin
                large_found = 1'b1;
                large_sel   = SLOT_W'(j);
            end
        end
    end

    assign idx_ok   = {{(32-rtcsp_pkg::IDX_W){1'b0}}, idx_reg} < 32'(TOTAL);
    assign idx_sel  = SLOT_W'(idx_reg);
    assign refs_at  = refs_reg[idx_sel];
    assign refs_dec = (refs_at != '0) ? (refs_at - REF_ONE) : '0;

    always_comb
    begin
        status_next = rtcsp_pkg::ST_OK;
        grant_next  = '0;
        last_next   = 1'b0;
        wr_en       = 1'b0;
        wr_slot     = idx_sel;
        wr_busy     = busy_reg[idx_sel];
        wr_refs     = refs_at;
        wr_len      = len_reg[idx_sel];
        case (cmd_reg)
            rtcsp_pkg::CMD_ACQUIRE:
            begin
                if (size_reg > max_size)
                    status_next = rtcsp_pkg::ST_TOO_LARGE;
                else if ((size_reg <= small_limit && small_found) || large_found)
                begin
                    wr_en   = 1'b1;
                    wr_slot = (size_reg <= small_limit && small_found) ? small_sel : large_sel;
                    wr_busy = 1'b1;
                    wr_refs = REF_ONE;
                    wr_len  = size_reg;
                    grant_next = rtcsp_pkg::IDX_W'(wr_slot);
                end
                else
                    status_next = rtcsp_pkg::ST_EXHAUSTED;
            end
            rtcsp_pkg::CMD_RETAIN:
            begin
                if (!idx_ok)
                    status_next = rtcsp_pkg::ST_NULL;
                else if (!busy_reg[idx_sel] || refs_at >= REF_MAX)
                    status_next = rtcsp_pkg::ST_COUNT;
                else
                begin
                    wr_en   = 1'b1;
                    wr_refs = refs_at + REF_ONE;
                end
            end
            rtcsp_pkg::CMD_RELEASE:
            begin
                if (!idx_ok)
                    status_next = rtcsp_pkg::ST_NULL;
                else if (!busy_reg[idx_sel])
                    status_next = rtcsp_pkg::ST_COUNT;
                else
                begin
                    wr_en   = 1'b1;
                    wr_refs = refs_dec;
                    if (refs_dec == '0)
                    begin
                        wr_busy   = 1'b0;
                        wr_len    = '0;
                        last_next = 1'b1;
                    end
                end
            end
            default:
                status_next = rtcsp_pkg::ST_NULL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            for (int k = 0; k < TOTAL; k++)
            begin
                refs_reg[k] <= '0;
                len_reg[k]  <= '0;
            end
        end
        else if (cmd.execute && wr_en)
        begin
            busy_reg[wr_slot] <= wr_busy;
            refs_reg[wr_slot] <= wr_refs;
            len_reg[wr_slot]  <= wr_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            last_reg   <= last_next;
        end
    end

    assign status       = status_reg;
    assign granted_slot = grant_reg;
    assign was_last     = last_reg;

endmodule

`default_nettype wire
